@@ src/tcc_pkg.sv @@
// Shared types, constants and helpers for the threshold color clustering block.
package tcc_pkg;

  // Palette size and the widths that follow from it.
  localparam int PALETTE_ENTRIES = 64;
  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

  // Fixed field widths.
  localparam int COMP_W   = 8;
  localparam int COLOR_W  = 3 * COMP_W;
  localparam int HITS_W   = 32;
  localparam int LIMIT_W  = 9;
  localparam int SQ_W     = 2 * COMP_W;
  localparam int DIST_W   = 2 * LIMIT_W;
  localparam int OUT_IDX_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
  localparam logic [HITS_W-1:0]  HITS_MAX    = '1;

  // One pixel word.
  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pixel_t;

  // One result word.
  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 is_new;
    logic [HITS_W-1:0]    hit_count;
    logic                 table_full;
  } result_t;

  // Match report from the distance unit to the scan control.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [HITS_W-1:0] hits;
  } match_t;

  // Absolute difference of two color components.
  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ src/tcc_palette_ram.sv @@
// Palette storage: entry colors and hit counts, one write and one read port.
module tcc_palette_ram (
  input  logic                       clk,
  input  logic                       wr_color_en,
  input  logic                       wr_hits_en,
  input  logic [tcc_pkg::IDX_W-1:0]  wr_addr,
  input  logic [tcc_pkg::COLOR_W-1:0] wr_color,
  input  logic [tcc_pkg::HITS_W-1:0] wr_hits,
  input  logic [tcc_pkg::IDX_W-1:0]  rd_addr,
  output logic [tcc_pkg::COLOR_W-1:0] rd_color,
  output logic [tcc_pkg::HITS_W-1:0] rd_hits
);
  import tcc_pkg::*;

  logic [COLOR_W-1:0] color_mem [PALETTE_ENTRIES];
  logic [HITS_W-1:0]  hits_mem  [PALETTE_ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_color_en) begin
      color_mem[wr_addr] <= wr_color;
    end
    if (wr_hits_en) begin
      hits_mem[wr_addr] <= wr_hits;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_color <= color_mem[rd_addr];
    rd_hits  <= hits_mem[rd_addr];
  end

endmodule

@@ src/tcc_dist.sv @@
// Distance unit: squared color distance of a stored entry against the pixel.
module tcc_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        flush,
  input  logic                        in_valid,
  input  logic [tcc_pkg::IDX_W-1:0]   in_idx,
  input  logic [tcc_pkg::COLOR_W-1:0] in_color,
  input  logic [tcc_pkg::HITS_W-1:0]  in_hits,
  input  tcc_pkg::pixel_t             pixel,
  input  logic [tcc_pkg::DIST_W-1:0]  limit_sq,
  output tcc_pkg::match_t             match,
  output logic                        busy
);
  import tcc_pkg::*;

  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic [HITS_W-1:0] s1_hits;
  logic [SQ_W-1:0]   s1_sq_r;
  logic [SQ_W-1:0]   s1_sq_g;
  logic [SQ_W-1:0]   s1_sq_b;
  logic [COMP_W-1:0] d_r;
  logic [COMP_W-1:0] d_g;
  logic [COMP_W-1:0] d_b;
  logic [DIST_W-1:0] dist_sum;

  // Per-component differences.
  always_comb begin
    d_r = abs_diff(in_color[3*COMP_W-1:2*COMP_W], pixel.red);
    d_g = abs_diff(in_color[2*COMP_W-1:COMP_W], pixel.green);
    d_b = abs_diff(in_color[COMP_W-1:0], pixel.blue);
  end

  // Stage one: the three squares are registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && !flush;
    end
    s1_idx  <= in_idx;
    s1_hits <= in_hits;
    s1_sq_r <= SQ_W'(d_r) * SQ_W'(d_r);
    s1_sq_g <= SQ_W'(d_g) * SQ_W'(d_g);
    s1_sq_b <= SQ_W'(d_b) * SQ_W'(d_b);
  end

  // Stage two: sum and compare against the squared limit.
  always_comb begin
    dist_sum   = DIST_W'(s1_sq_r) + DIST_W'(s1_sq_g) + DIST_W'(s1_sq_b);
    match.hit  = s1_valid && (dist_sum < limit_sq);
    match.idx  = s1_idx;
    match.hits = s1_hits;
  end

  assign busy = s1_valid;

endmodule

@@ src/threshold_color_clustering_top.sv @@
// Top level of the threshold color clustering block: scan control and result register.
//
//   channel | signals                       | word
//   --------+-------------------------------+-------------------------------
//   in      | in_valid, in_ready, in_data   | pixel_t (red, green, blue)
//   out     | out_valid, out_ready, out_data| result_t (index, new, count, full)
//   cfg     | cfg_valid, cfg_ready, cfg_data| 9-bit distance limit
//
// The scan reads one palette entry per cycle from the RAM port, in index order, and
// ends when an entry matches or when every entry in use has been checked. Reset is
// synchronous, empties the palette and sets the limit to 16; RAM contents are not
// cleared. A new pixel is taken as soon as the previous result sits in the output
// register; a stalled output holds the finished scan until the register frees.
module threshold_color_clustering_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tcc_pkg::pixel_t             in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tcc_pkg::result_t            out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcc_pkg::LIMIT_W-1:0] cfg_data
);
  import tcc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  pixel_t             pixel;
  logic [DIST_W-1:0]  limit_sq;
  logic [CNT_W-1:0]   used;
  logic [CNT_W-1:0]   issue_cnt;
  logic               rd_valid_q;
  logic [IDX_W-1:0]   rd_idx_q;
  result_t            res;
  logic               res_write;
  logic [IDX_W-1:0]   res_addr;

  logic [COLOR_W-1:0] rd_color;
  logic [HITS_W-1:0]  rd_hits;
  match_t             match;
  logic               dist_busy;
  logic               issue;
  logic               scan_end;
  logic               out_free;
  logic [HITS_W-1:0]  hits_inc;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Issue one entry read per cycle until the used entries are covered or an entry matches.
  assign issue    = (state == ST_SCAN) && (issue_cnt < used) && !match.hit;
  assign scan_end = (state == ST_SCAN) && (issue_cnt == used) && !rd_valid_q
                    && !dist_busy && !match.hit;
  assign hits_inc = (match.hits == HITS_MAX) ? match.hits : match.hits + 1'b1;

  tcc_palette_ram u_ram (
    .clk         (clk),
    .wr_color_en (state == ST_DONE && out_free && res_write && res.is_new),
    .wr_hits_en  (state == ST_DONE && out_free && res_write),
    .wr_addr     (res_addr),
    .wr_color    ({pixel.red, pixel.green, pixel.blue}),
    .wr_hits     (res.hit_count),
    .rd_addr     (issue_cnt[IDX_W-1:0]),
    .rd_color    (rd_color),
    .rd_hits     (rd_hits)
  );

  tcc_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .flush    (match.hit),
    .in_valid (rd_valid_q),
    .in_idx   (rd_idx_q),
    .in_color (rd_color),
    .in_hits  (rd_hits),
    .pixel    (pixel),
    .limit_sq (limit_sq),
    .match    (match),
    .busy     (dist_busy)
  );

  // State sequencing.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match.hit || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      rd_valid_q <= 1'b0;
      out_valid  <= 1'b0;
      limit_sq   <= DIST_W'(LIMIT_RESET) * DIST_W'(LIMIT_RESET);
    end else begin
      state      <= state_next;
      rd_valid_q <= issue;
      if (cfg_valid) begin
        limit_sq <= DIST_W'(cfg_data) * DIST_W'(cfg_data);
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
        if (res_write && res.is_new) begin
          used <= used + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan counter, pixel, pending result and output word.
  always_ff @(posedge clk) begin
    rd_idx_q <= issue_cnt[IDX_W-1:0];
    if (state == ST_IDLE && in_valid) begin
      pixel     <= in_data;
      issue_cnt <= '0;
    end else if (issue) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
    if (state == ST_SCAN && match.hit) begin
      res.entry_index <= OUT_IDX_W'(match.idx);
      res.is_new      <= 1'b0;
      res.hit_count   <= hits_inc;
      res.table_full  <= 1'b0;
      res_write       <= 1'b1;
      res_addr        <= match.idx;
    end else if (scan_end) begin
      res_addr <= used[IDX_W-1:0];
      if (used == CNT_W'(PALETTE_ENTRIES)) begin
        res.entry_index <= '0;
        res.is_new      <= 1'b0;
        res.hit_count   <= '0;
        res.table_full  <= 1'b1;
        res_write       <= 1'b0;
      end else begin
        res.entry_index <= OUT_IDX_W'(used[IDX_W-1:0]);
        res.is_new      <= 1'b1;
        res.hit_count   <= HITS_W'(1);
        res.table_full  <= 1'b0;
        res_write       <= 1'b1;
      end
    end
    if (state == ST_DONE && out_free) begin
      out_data <= res;
    end
  end

endmodule

@@ test/tb_threshold_color_clustering_top.sv @@
// Self-checking testbench for the threshold color clustering block.
`timescale 1ns / 100ps

module tb_threshold_color_clustering_top;
  import tcc_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pixel_t              in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  result_t             out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data = '0;

  // Testbench copy of the palette and the distance limit.
  pixel_t              pal_colour [PALETTE_ENTRIES];
  logic [HITS_W-1:0]   pal_hits [PALETTE_ENTRIES];
  int                  pal_used = 0;
  logic [LIMIT_W-1:0]  cur_limit = LIMIT_RESET;

  pixel_t              pending_pixels [$];
  result_t             expected_results [$];
  pixel_t              cluster_centers [$];
  int                  mismatch_count = 0;
  int                  results_seen = 0;

  // Sender burst state and receiver stall state.
  int                  burst_left = 1;
  int                  gap_left = 0;
  int                  hold_left = 0;
  bit                  long_hold_done = 1'b0;
  logic [15:0]         stall_pat = 16'hFFFF;
  int                  pat_age = 0;

  threshold_color_clustering_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Scan the palette in creation order, count the first close entry or append a new one while there is room.
  function automatic result_t cluster_pixel(input pixel_t px);
    result_t     res;
    int unsigned limit_sq;
    int unsigned sq_dist;
    int          dr;
    int          dg;
    int          db;
    res = '0;
    limit_sq = int'(cur_limit) * int'(cur_limit);
    for (int k = 0; k < pal_used; k++) begin
      dr = int'(pal_colour[k].red) - int'(px.red);
      dg = int'(pal_colour[k].green) - int'(px.green);
      db = int'(pal_colour[k].blue) - int'(px.blue);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist < limit_sq) begin
        if (pal_hits[k] != HITS_MAX) begin
          pal_hits[k] = pal_hits[k] + 1;
        end
        res.entry_index = OUT_IDX_W'(k);
        res.hit_count = pal_hits[k];
        return res;
      end
    end
    // No entry is close enough: drop the pixel if the palette is full.
    if (pal_used >= PALETTE_ENTRIES) begin
      res.table_full = 1'b1;
      return res;
    end
    pal_colour[pal_used] = px;
    pal_hits[pal_used] = 1;
    res.entry_index = OUT_IDX_W'(pal_used);
    res.is_new = 1'b1;
    res.hit_count = 1;
    pal_used++;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // Sender: offers queued pixels in bursts and predicts each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(cluster_pixel(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_pixels.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and stalls on a rotating pattern.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (out_data.entry_index != want.entry_index)
            report_mismatch($sformatf("word %0d entry_index %0d, expected %0d",
                            results_seen, out_data.entry_index, want.entry_index));
          if (out_data.is_new != want.is_new)
            report_mismatch($sformatf("word %0d is_new %0b, expected %0b",
                            results_seen, out_data.is_new, want.is_new));
          if (out_data.hit_count != want.hit_count)
            report_mismatch($sformatf("word %0d hit_count %0d, expected %0d",
                            results_seen, out_data.hit_count, want.hit_count));
          if (out_data.table_full != want.table_full)
            report_mismatch($sformatf("word %0d table_full %0b, expected %0b",
                            results_seen, out_data.table_full, want.table_full));
        end
      end
      // One long hold-off mid-run lets the block back up into its input.
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!long_hold_done && results_seen >= 300) begin
        out_ready <= 1'b0;
        hold_left <= 400;
        long_hold_done <= 1'b1;
      end else begin
        out_ready <= stall_pat[0];
        if (pat_age >= 63) begin
          pat_age <= 0;
          stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end else begin
          pat_age <= pat_age + 1;
          stall_pat <= {stall_pat[0], stall_pat[15:1]};
        end
      end
    end
  end

  function automatic logic [COMP_W-1:0] jitter(input logic [COMP_W-1:0] c, input int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COMP_W'(v);
  endfunction

  function automatic pixel_t make_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.red = COMP_W'(r);
    px.green = COMP_W'(g);
    px.blue = COMP_W'(b);
    return px;
  endfunction

  // Mostly pixels scattered around known cluster centers, plus new centers and noise.
  task automatic queue_random_pixels(input int count, input int limit_now);
    int     spread;
    int     pick;
    pixel_t px;
    spread = (limit_now / 2 > 40) ? 40 : ((limit_now < 8) ? 4 : limit_now / 2);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      px = pixel_t'($urandom);
      if (pick < 8 || cluster_centers.size() == 0) begin
        cluster_centers.push_back(px);
      end else if (pick < 88) begin
        px = cluster_centers[$urandom_range(0, cluster_centers.size() - 1)];
        px.red = jitter(px.red, spread);
        px.green = jitter(px.green, spread);
        px.blue = jitter(px.blue, spread);
      end
      pending_pixels.push_back(px);
    end
  endtask

  // Hold the stimulus sequence until every queued pixel has produced its result.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_limit(input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= LIMIT_W'(value);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    cur_limit = LIMIT_W'(value);
  endtask

  // Stimulus sequence.
  initial begin
    int phase_limits [8] = '{16, 40, 3, 100, 0, 10, 250, 60};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset limit of 16: extremes, primaries and the boundary of the strict compare.
    pending_pixels.push_back(make_pixel(0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 255, 255));
    pending_pixels.push_back(make_pixel(0, 0, 0));
    pending_pixels.push_back(make_pixel(15, 0, 0));
    pending_pixels.push_back(make_pixel(16, 0, 0));
    pending_pixels.push_back(make_pixel(9, 9, 9));
    pending_pixels.push_back(make_pixel(255, 255, 240));
    pending_pixels.push_back(make_pixel(255, 255, 239));
    pending_pixels.push_back(make_pixel(255, 0, 0));
    pending_pixels.push_back(make_pixel(0, 255, 0));
    pending_pixels.push_back(make_pixel(0, 0, 255));
    pending_pixels.push_back(make_pixel(8'hAA, 8'h55, 8'hAA));
    pending_pixels.push_back(make_pixel(8'h55, 8'hAA, 8'h55));
    wait_drained();

    // Zero limit: even an exact color match creates a new entry.
    write_limit(0);
    pending_pixels.push_back(make_pixel(0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 255, 255));
    wait_drained();

    // Limits at and past the largest possible distance: everything joins entry zero.
    write_limit(511);
    pending_pixels.push_back(make_pixel(8'h12, 8'h34, 8'h56));
    pending_pixels.push_back(make_pixel(255, 255, 255));
    wait_drained();
    write_limit(442);
    pending_pixels.push_back(make_pixel(255, 255, 255));
    pending_pixels.push_back(make_pixel(0, 0, 0));
    wait_drained();

    // Limit of one: only an exact color joins an entry.
    write_limit(1);
    pending_pixels.push_back(make_pixel(8'h55, 8'hAA, 8'h55));
    pending_pixels.push_back(make_pixel(8'h55, 8'hAA, 8'h54));
    wait_drained();

    // Random phases over several limits; the palette fills and drops begin.
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      queue_random_pixels(115, phase_limits[p]);
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS threshold_color_clustering_top");
    end else begin
      $display("FAIL threshold_color_clustering_top");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL threshold_color_clustering_top");
    $finish;
  end

endmodule

@@ filelist.f @@
src/tcc_pkg.sv
src/tcc_palette_ram.sv
src/tcc_dist.sv
src/threshold_color_clustering_top.sv
test/tb_threshold_color_clustering_top.sv
